FILE: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted table search
// Command and register codes, search methods, sequencer states and the
// Fibonacci constant table used by the Fibonacci split search.
// ----------------------------------------------------------------------------
package sts_pkg;

	// payload widths of the stream fields
	localparam int POS_W      = 7;
	localparam int VAL_W      = 32;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_DATA_W = 7;
	localparam int REG_IDX_W  = 1;

	// command codes (tuser of the input stream)
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_METHOD      = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b1;

	// search methods; the unused code searches as binary
	typedef enum logic [1:0] {
		METHOD_BINARY = 2'd0,
		METHOD_INTERP = 2'd1,
		METHOD_FIB    = 2'd2
	} method_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIB_INIT,
		ST_LOOP,
		ST_RD_LO,
		ST_RD_HI,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_MID,
		ST_PROBE,
		ST_FINISH
	} state_t;

	// Fibonacci table: 20 entries, enough for tables up to 1024 entries
	localparam int FIB_DEPTH = 20;
	localparam int FIB_W     = 13;
	localparam int K_W       = 5;

	function automatic logic [FIB_W-1:0] fib_at(input logic [K_W-1:0] idx);
		logic [FIB_W-1:0] f;
		case (idx)
			5'd0:    f = 13'd0;
			5'd1:    f = 13'd1;
			5'd2:    f = 13'd1;
			5'd3:    f = 13'd2;
			5'd4:    f = 13'd3;
			5'd5:    f = 13'd5;
			5'd6:    f = 13'd8;
			5'd7:    f = 13'd13;
			5'd8:    f = 13'd21;
			5'd9:    f = 13'd34;
			5'd10:   f = 13'd55;
			5'd11:   f = 13'd89;
			5'd12:   f = 13'd144;
			5'd13:   f = 13'd233;
			5'd14:   f = 13'd377;
			5'd15:   f = 13'd610;
			5'd16:   f = 13'd987;
			5'd17:   f = 13'd1597;
			5'd18:   f = 13'd2584;
			5'd19:   f = 13'd4181;
			default: f = 13'd0;
		endcase
		return f;
	endfunction

endpackage

FILE: sv/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/sorted_table_search.sv
// ----------------------------------------------------------------------------
// sorted_table_search: search of a sorted table by binary, interpolation
// or Fibonacci split
// Write beats store one entry; search beats return found and position.
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores its value at table position 1..TABLE_DEPTH
// and the block is ready again on the next cycle; writes to other positions
// are dropped. A search beat (tuser 1) holds the input for the whole search
// and returns one result beat. All probes go through the single read port of
// the table RAM, whose registered read sets the pace. Fibonacci search first
// steps through its constant table and then probes; interpolation, for each
// probe, reads both ends, multiplies and runs a restoring divider that retires
// one quotient bit per cycle over a W-bit quotient, W = clog2(TABLE_DEPTH+1)+1
// (W is 8 for 64 entries). A finished result waits in the output register,
// and write beats are still taken while it waits. Configuration writes are
// always ready.
module sorted_table_search import sts_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [6:0] position, [38:7] value, [39] zero
	input  logic                  s_tuser,   // [0] cmd
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // [0] found, [7:1] match_position
);

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int PW   = $clog2(TABLE_DEPTH + 1) + 1;
	localparam int CW   = (PW > FIB_W) ? PW : FIB_W;
	localparam int DW   = VAL_W + 1;
	localparam int PRW  = DW + PW;
	localparam int CNTW = $clog2(PW + 1);

	// control registers
	state_t              state_q, state_d;
	logic [1:0]          method_q;
	logic [POS_W-1:0]    entry_count_q;
	logic [K_W-1:0]      k_q;
	logic [CNTW-1:0]     cnt_q;
	logic                out_valid_q;

	// datapath registers
	logic [PW-1:0]       lo_q, hi_q, mid_q, n_q;
	logic signed [VAL_W-1:0] key_q, vl_q, vh_q;
	logic [DW-1:0]       diff_q, den_q, rem_q;
	logic [PW-1:0]       quo_q;
	logic                res_found_q;
	logic [PW-1:0]       res_pos_q;
	logic                out_found_q;
	logic [POS_W-1:0]    out_pos_q;

	// sequencer outputs
	logic [PW-1:0]       raddr_pos;
	logic                fin_set, fin_found;
	logic [PW-1:0]       fin_pos;
	logic                out_load;

	// input decode
	logic                s_accept, is_search;
	logic [POS_W-1:0]    in_pos;
	logic signed [VAL_W-1:0] in_val;
	logic [CW-1:0]       in_pos_ext, in_pos_m1, ec_ext, n_init_w;
	logic [PW-1:0]       n_init;
	logic                wr_ok;

	// table RAM
	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [PW-1:0]       raddr_m1;
	logic [VAL_W-1:0]    ram_rdata;
	logic signed [VAL_W-1:0] rd_val;

	// shared compare / arithmetic
	logic                is_fib, is_interp;
	logic                lo_gt_hi, key_eq, key_lt, key_out;
	logic [PW-1:0]       span, bin_mid, int_mid, fib_mid, fib_clamp, hit_pos;
	logic [K_W-1:0]      k_m1;
	logic [CW-1:0]       fib_mid_w;
	logic                fib_le_n, fib_stop;
	logic [PRW-1:0]      prod;
	logic [DW:0]         div_t, div_sub;
	logic                div_ge;

	assign is_fib    = (method_q == METHOD_FIB);
	assign is_interp = (method_q == METHOD_INTERP);

	// input beat decode
	assign s_tready   = (state_q == ST_IDLE);
	assign s_accept   = s_tvalid & s_tready;
	assign is_search  = (s_tuser == CMD_SEARCH);
	assign in_pos     = s_tdata[POS_W-1:0];
	assign in_val     = $signed(s_tdata[POS_W+VAL_W-1:POS_W]);
	assign in_pos_ext = CW'(in_pos);
	assign in_pos_m1  = in_pos_ext - CW'(1);
	assign wr_ok      = (in_pos != '0) && (in_pos_ext <= CW'(TABLE_DEPTH));

	// entry count clamped to the table depth
	assign ec_ext   = CW'(entry_count_q);
	assign n_init_w = (ec_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : ec_ext;
	assign n_init   = n_init_w[PW-1:0];

	// table RAM ports
	assign ram_we    = s_accept && !is_search && wr_ok;
	assign ram_waddr = in_pos_m1[AW-1:0];
	assign raddr_m1  = raddr_pos - PW'(1);
	assign ram_raddr = raddr_m1[AW-1:0];
	assign rd_val    = $signed(ram_rdata);

	sts_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(s_tdata[POS_W+VAL_W-1:POS_W]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// probe compares
	assign lo_gt_hi = (lo_q > hi_q);
	assign key_eq   = (key_q == rd_val);
	assign key_lt   = (key_q < rd_val);
	assign key_out  = (key_q < vl_q) || (key_q > vh_q);

	// probe positions
	assign span      = hi_q - lo_q;
	assign bin_mid   = lo_q + (span >> 1);
	assign int_mid   = lo_q + quo_q;
	assign k_m1      = k_q - K_W'(1);
	assign fib_mid_w = CW'(lo_q) + CW'(fib_at(k_m1)) - CW'(1);
	assign fib_mid   = fib_mid_w[PW-1:0];
	assign fib_clamp = (fib_mid > n_q) ? n_q : fib_mid;
	assign hit_pos   = (is_fib && (mid_q > n_q)) ? n_q : mid_q;
	assign fib_le_n  = (CW'(fib_at(k_q)) <= CW'(n_q));
	// Fibonacci index would drop below one
	assign fib_stop  = key_lt ? (k_q == K_W'(1)) : (k_q <= K_W'(2));

	// interpolation multiply and one restoring divide step
	assign prod    = PRW'(diff_q) * PRW'(span);
	assign div_t   = {rem_q, quo_q[PW-1]};
	assign div_ge  = (div_t >= {1'b0, den_q});
	assign div_sub = div_t - {1'b0, den_q};

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and sequencer outputs
	always_comb begin
		state_d   = state_q;
		raddr_pos = lo_q;
		fin_set   = 1'b0;
		fin_found = 1'b0;
		fin_pos   = '0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept && is_search) begin
					state_d = is_fib ? ST_FIB_INIT : ST_LOOP;
				end
			end
			ST_FIB_INIT: begin
				if (!((k_q < K_W'(FIB_DEPTH - 1)) && fib_le_n)) begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (lo_gt_hi) begin
					fin_set = 1'b1;
					state_d = ST_FINISH;
				end else if (is_interp) begin
					raddr_pos = lo_q;
					state_d   = ST_RD_LO;
				end else if (is_fib) begin
					// probe below position one: never a hit
					if (fib_mid_w == '0) begin
						fin_set = 1'b1;
						state_d = ST_FINISH;
					end else begin
						raddr_pos = fib_clamp;
						state_d   = ST_PROBE;
					end
				end else begin
					raddr_pos = bin_mid;
					state_d   = ST_PROBE;
				end
			end
			ST_RD_LO: begin
				raddr_pos = hi_q;
				state_d   = ST_RD_HI;
			end
			ST_RD_HI: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (key_out) begin
					fin_set = 1'b1;
					state_d = ST_FINISH;
				end else if (vh_q == vl_q) begin
					raddr_pos = lo_q;
					state_d   = ST_PROBE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNTW'(PW - 1)) begin
					state_d = ST_MID;
				end
			end
			ST_MID: begin
				raddr_pos = int_mid;
				state_d   = ST_PROBE;
			end
			ST_PROBE: begin
				if (key_eq) begin
					fin_set   = 1'b1;
					fin_found = 1'b1;
					fin_pos   = hit_pos;
					state_d   = ST_FINISH;
				end else if (is_fib && fib_stop) begin
					fin_set = 1'b1;
					state_d = ST_FINISH;
				end else begin
					state_d = ST_LOOP;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q      <= METHOD_BINARY;
			entry_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_METHOD:      method_q      <= cfg_data[1:0];
				REG_ENTRY_COUNT: entry_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fibonacci index and divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE:     k_q <= '0;
				ST_FIB_INIT: if (state_d == ST_FIB_INIT) k_q <= k_q + K_W'(1);
				ST_PROBE: begin
					if (is_fib && !key_eq && !fib_stop) begin
						k_q <= key_lt ? k_q - K_W'(1) : k_q - K_W'(2);
					end
				end
				ST_MUL:      cnt_q <= '0;
				ST_DIV:      cnt_q <= cnt_q + CNTW'(1);
				default: ;
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_accept && is_search) begin
					key_q <= in_val;
					n_q   <= n_init;
					lo_q  <= PW'(1);
					hi_q  <= n_init;
				end
			end
			ST_LOOP: mid_q <= is_fib ? fib_mid : bin_mid;
			ST_RD_LO: vl_q <= rd_val;
			ST_RD_HI: vh_q <= rd_val;
			ST_CHECK: begin
				mid_q  <= lo_q;
				diff_q <= {key_q[VAL_W-1], key_q} - {vl_q[VAL_W-1], vl_q};
				den_q  <= {vh_q[VAL_W-1], vh_q} - {vl_q[VAL_W-1], vl_q};
			end
			ST_MUL: begin
				rem_q <= prod[PRW-1:PW];
				quo_q <= prod[PW-1:0];
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_sub[DW-1:0] : div_t[DW-1:0];
				quo_q <= {quo_q[PW-2:0], div_ge};
			end
			ST_MID: mid_q <= int_mid;
			ST_PROBE: begin
				if (!key_eq) begin
					if (key_lt) begin
						hi_q <= mid_q - PW'(1);
					end else begin
						lo_q <= mid_q + PW'(1);
					end
				end
			end
			default: ;
		endcase
		if (fin_set) begin
			res_found_q <= fin_found;
			res_pos_q   <= fin_pos;
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= res_found_q;
			out_pos_q   <= POS_W'(res_pos_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_pos_q, out_found_q};

	// a search beat closes the input until its result is handed off
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == CMD_SEARCH) |=> !s_tready)
		else $error("input ready right after a search beat");

	// a miss always reports position zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_DATA_W-1:1] == '0))
		else $error("miss with nonzero position");

	// the divider only runs with a nonzero divisor
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != '0))
		else $error("divide step with zero divisor");

	// Fibonacci split never probes with an exhausted index
	a_fib_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOP && method_q == METHOD_FIB) |-> (k_q != '0))
		else $error("Fibonacci index exhausted inside the loop");

	// a result only appears after the hand-off state
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_FINISH))
		else $error("result beat without a finished search");

endmodule
